// ----- sv/lfmp_pkg.sv -----
`default_nettype none

package lfmp_pkg;

   localparam int BUFFER_BYTES_DEF     = 4096;
   localparam int SIZE_FIELD_BYTES_DEF = 8;

   localparam logic [7:0] MAGIC_FIRST  = 8'hAA;
   localparam logic [7:0] MAGIC_SECOND = 8'h55;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_MAGIC = 3'd1;
   localparam logic [2:0] ERR_WIDTH = 3'd2;
   localparam logic [2:0] ERR_SHORT = 3'd3;
   localparam logic [2:0] ERR_LONG  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] frame_count;
      logic [7:0]  payload_byte;
      logic        last;
      logic [2:0]  error_code;
   } rsp_item_type;

   // parser stage to output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/lfmp_req_if.sv -----
`default_nettype none

interface lfmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

// ----- sv/lfmp_rsp_if.sv -----
`default_nettype none

interface lfmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] frame_count;
   logic [7:0]  payload_byte;
   logic        last;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output frame_count, output payload_byte,
                   output last, output error_code, input ready);
   modport sink (input valid, input kind, input frame_count, input payload_byte,
                 input last, input error_code, output ready);
endinterface

`default_nettype wire

// ----- sv/length_framed_message_parser_core.sv -----
// An accepted item is held in the input register; the parse logic writes its result into
// the result register, which offers it on rsp_chan. Throughput: one item per cycle while
// the result register has room; the result register frees in the cycle it drains.
// Items that cause no result pass the parse stage even while the result register is full.
// Reset (synchronous): empties both registers and returns the parser to idle.
`default_nettype none

module length_framed_message_parser_core #(
   parameter int BUFFER_BYTES     = lfmp_pkg::BUFFER_BYTES_DEF,
   parameter int SIZE_FIELD_BYTES = lfmp_pkg::SIZE_FIELD_BYTES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   lfmp_req_if.sink   req_chan,
   lfmp_rsp_if.source rsp_chan
);
   import lfmp_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         take;
   logic         out_room;
   result_type   result;

   lfmp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   lfmp_parse #(
      .BUFFER_BYTES     (BUFFER_BYTES),
      .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_room   (out_room),
      .take       (take),
      .result     (result)
   );

   lfmp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_room (out_room),
      .rsp_chan (rsp_chan)
   );

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !result.valid)
      else $error("result pushed into a full output register");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_ERROR) |->
         (rsp_chan.last && rsp_chan.error_code != ERR_NONE))
      else $error("error result without last or code");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != KIND_ERROR) |-> (rsp_chan.error_code == ERR_NONE))
      else $error("error code on a non-error result");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> item_valid)
      else $error("parse stage took an empty input register");

endmodule

`default_nettype wire

// ----- sv/lfmp_in_stage.sv -----
`default_nettype none

module lfmp_in_stage (
   input  wire                   clock,
   input  wire                   reset,
   lfmp_req_if.sink              req_chan,
   input  wire                   take,
   output logic                  item_valid,
   output lfmp_pkg::req_item_type item
);
   import lfmp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte <= req_chan.data_byte;
         item_ff.start_req <= req_chan.start_req;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- sv/lfmp_parse.sv -----
`default_nettype none

module lfmp_parse #(
   parameter int BUFFER_BYTES     = lfmp_pkg::BUFFER_BYTES_DEF,
   parameter int SIZE_FIELD_BYTES = lfmp_pkg::SIZE_FIELD_BYTES_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    item_valid,
   input  lfmp_pkg::req_item_type item,
   input  wire                    out_room,
   output logic                   take,
   output lfmp_pkg::result_type   result
);
   import lfmp_pkg::*;

   localparam int IDX_W        = $clog2(SIZE_FIELD_BYTES);
   localparam int FIELD_W      = 8 * SIZE_FIELD_BYTES;
   localparam int HEADER_BYTES = 3 + 2 * SIZE_FIELD_BYTES;
   localparam int REM_W        = $clog2(BUFFER_BYTES + 1);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_MAGIC2  = 3'd1;
   localparam logic [2:0] PH_WIDTH   = 3'd2;
   localparam logic [2:0] PH_LENGTH  = 3'd3;
   localparam logic [2:0] PH_FRAMES  = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   logic [2:0]         phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [FIELD_W-1:0] length_ff, length_in;
   logic [FIELD_W-1:0] frames_ff, frames_in;
   logic [REM_W-1:0]   remain_ff, remain_in;

   logic [FIELD_W-1:0] shifted;
   logic [FIELD_W-1:0] length_full;
   logic [FIELD_W-1:0] frames_full;
   logic [63:0]        length_wide;
   logic [63:0]        payload_len;
   logic               field_done;
   rsp_item_type       res;
   logic               res_valid;

   assign shifted     = FIELD_W'(item.data_byte) << {idx_ff, 3'b000};
   assign length_full = length_ff | shifted;
   assign frames_full = frames_ff | shifted;
   assign length_wide = 64'(length_full);
   assign payload_len = length_wide - 64'(HEADER_BYTES);
   assign field_done  = (idx_ff == IDX_W'(SIZE_FIELD_BYTES - 1));

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      length_in = length_ff;
      frames_in = frames_ff;
      remain_in = remain_ff;
      res_valid = 1'b0;
      res       = '0;

      if (item.start_req) begin
         idx_in    = '0;
         length_in = '0;
         frames_in = '0;
         remain_in = '0;
         if (item.data_byte != MAGIC_FIRST) begin
            phase_in       = PH_IDLE;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.last       = 1'b1;
            res.error_code = ERR_MAGIC;
         end else begin
            phase_in = PH_MAGIC2;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_MAGIC2: begin
               if (item.data_byte != MAGIC_SECOND) begin
                  phase_in       = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.last       = 1'b1;
                  res.error_code = ERR_MAGIC;
               end else begin
                  phase_in = PH_WIDTH;
               end
            end
            PH_WIDTH: begin
               if (item.data_byte != 8'(SIZE_FIELD_BYTES)) begin
                  phase_in       = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.last       = 1'b1;
                  res.error_code = ERR_WIDTH;
               end else begin
                  idx_in   = '0;
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               length_in = length_full;
               idx_in    = idx_ff + IDX_W'(1);
               if (field_done) begin
                  if (length_wide < 64'(HEADER_BYTES)) begin
                     phase_in       = PH_IDLE;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.last       = 1'b1;
                     res.error_code = ERR_SHORT;
                  end else if (length_wide > 64'(BUFFER_BYTES)) begin
                     phase_in       = PH_IDLE;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.last       = 1'b1;
                     res.error_code = ERR_LONG;
                  end else begin
                     remain_in = REM_W'(payload_len);
                     idx_in    = '0;
                     phase_in  = PH_FRAMES;
                  end
               end
            end
            PH_FRAMES: begin
               frames_in = frames_full;
               idx_in    = idx_ff + IDX_W'(1);
               if (field_done) begin
                  idx_in          = '0;
                  res_valid       = 1'b1;
                  res.kind        = KIND_HEADER;
                  res.frame_count = 64'(frames_full);
                  res.last        = (remain_ff == '0);
                  phase_in        = (remain_ff == '0) ? PH_IDLE : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               // remaining count is never zero here
               remain_in        = remain_ff - REM_W'(1);
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = item.data_byte;
               res.last         = (remain_ff == REM_W'(1));
               if (remain_ff == REM_W'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // an item with no result never waits on the output register
   assign take = item_valid && (!res_valid || out_room);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         idx_ff    <= '0;
         remain_ff <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         length_ff <= length_in;
         frames_ff <= frames_in;
      end
   end

   assign result.valid = take && res_valid;
   assign result.item  = res;

endmodule

`default_nettype wire

// ----- sv/lfmp_out_stage.sv -----
`default_nettype none

module lfmp_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  lfmp_pkg::result_type result,
   output logic                 out_room,
   lfmp_rsp_if.source           rsp_chan
);
   import lfmp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         drain;

   assign drain    = valid_ff && rsp_chan.ready;
   assign out_room = !valid_ff || rsp_chan.ready;
   assign valid_in = result.valid ? 1'b1 : (drain ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         item_ff <= result.item;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = item_ff.kind;
   assign rsp_chan.frame_count  = item_ff.frame_count;
   assign rsp_chan.payload_byte = item_ff.payload_byte;
   assign rsp_chan.last         = item_ff.last;
   assign rsp_chan.error_code   = item_ff.error_code;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   import lfmp_pkg::*;

   localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
   localparam int FIELD_BYTES  = SIZE_FIELD_BYTES_DEF;
   localparam int HEADER_BYTES = 3 + 2 * FIELD_BYTES;
   localparam int TARGET_ITEMS = 850;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 40;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_MAGIC2  = 3'd1;
   localparam logic [2:0] PH_WIDTH   = 3'd2;
   localparam logic [2:0] PH_LENGTH  = 3'd3;
   localparam logic [2:0] PH_FRAMES  = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   typedef struct {
      logic [7:0] data_byte;
      logic       start_req;
      int         gap;
   } byte_slot_type;

   logic clock = 1'b0;
   logic reset;

   lfmp_req_if req_chan ();
   lfmp_rsp_if rsp_chan ();

   length_framed_message_parser_core #(
      .BUFFER_BYTES     (BUFFER_BYTES),
      .SIZE_FIELD_BYTES (FIELD_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_slot_type byte_stream[$];
   rsp_item_type  parse_results[$];
   logic [7:0]    msg_bytes[$];

   // shadow parser state
   logic [2:0]   sh_phase = PH_IDLE;
   int           sh_index = 0;
   logic [63:0]  sh_total = '0;
   logic [63:0]  sh_frames = '0;
   logic [63:0]  sh_left = '0;

   int n_errors = 0;
   int n_results = 0;
   int n_headers = 0;
   int n_payload = 0;
   int n_faults = 0;
   int n_counted = 0;
   int n_accepted = 0;
   int cyc = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit send_calm = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      n_errors++;
      if (n_errors <= PRINT_LIMIT)
         $display("mismatch at cycle %0d, result %0d: %s got %0h want %0h",
                  cyc, n_results, what, got, want);
   endtask

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic bit flag_error(output rsp_item_type r, input logic [2:0] code);
      r = '0;
      r.kind = KIND_ERROR;
      r.last = 1'b1;
      r.error_code = code;
      sh_phase = PH_IDLE;
      return 1'b1;
   endfunction

   // Advance the shadow parser by one byte; returns 1 when the byte yields a result.
   function automatic bit parse_byte(input logic [7:0] b, input logic s,
                                     output rsp_item_type r);
      r = '0;
      if (s) begin
         sh_index = 0;
         sh_total = '0;
         sh_frames = '0;
         sh_left = '0;
         if (b != MAGIC_FIRST) return flag_error(r, ERR_MAGIC);
         sh_phase = PH_MAGIC2;
         return 1'b0;
      end
      case (sh_phase)
         PH_MAGIC2: begin
            if (b != MAGIC_SECOND) return flag_error(r, ERR_MAGIC);
            sh_phase = PH_WIDTH;
         end
         PH_WIDTH: begin
            if (b != 8'(FIELD_BYTES)) return flag_error(r, ERR_WIDTH);
            sh_index = 0;
            sh_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            sh_total = sh_total | (64'(b) << (8 * sh_index));
            sh_index++;
            if (sh_index >= FIELD_BYTES) begin
               if (sh_total < 64'(HEADER_BYTES)) return flag_error(r, ERR_SHORT);
               if (sh_total > 64'(BUFFER_BYTES)) return flag_error(r, ERR_LONG);
               sh_left = sh_total - 64'(HEADER_BYTES);
               sh_index = 0;
               sh_phase = PH_FRAMES;
            end
         end
         PH_FRAMES: begin
            sh_frames = sh_frames | (64'(b) << (8 * sh_index));
            sh_index++;
            if (sh_index >= FIELD_BYTES) begin
               sh_index = 0;
               r.kind = KIND_HEADER;
               r.frame_count = sh_frames;
               r.last = (sh_left == 0);
               sh_phase = (sh_left == 0) ? PH_IDLE : PH_PAYLOAD;
               return 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (sh_left > 0) sh_left--;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            if (sh_left == 0) begin
               r.last = 1'b1;
               sh_phase = PH_IDLE;
            end
            return 1'b1;
         end
         default: sh_phase = PH_IDLE;
      endcase
      return 1'b0;
   endfunction

   // stimulus helpers
   task automatic put_byte(input logic [7:0] b, input logic s);
      byte_slot_type slot;
      slot.data_byte = b;
      slot.start_req = s;
      slot.gap = pick_gap(send_calm);
      byte_stream.insert(byte_stream.size(), slot);
   endtask

   task automatic add_msg_byte(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endtask

   task automatic build_msg(input logic [7:0] m1, input logic [7:0] m2, input logic [7:0] w,
                            input logic [63:0] total, input logic [63:0] frames,
                            input int n_pay);
      msg_bytes.delete();
      add_msg_byte(m1);
      add_msg_byte(m2);
      add_msg_byte(w);
      for (int i = 0; i < FIELD_BYTES; i++) add_msg_byte(total[8*i +: 8]);
      for (int i = 0; i < FIELD_BYTES; i++) add_msg_byte(frames[8*i +: 8]);
      for (int i = 0; i < n_pay; i++) add_msg_byte(8'($urandom_range(0, 255)));
   endtask

   // Send the first keep bytes of the built message; count only those the parser acts on.
   task automatic send_msg(input int keep, input int useful);
      for (int i = 0; i < keep && i < msg_bytes.size(); i++) put_byte(msg_bytes[i], i == 0);
      n_counted += (useful < keep) ? useful : keep;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int pick_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 8);
      if (r < 95) return $urandom_range(9, 40);
      return $urandom_range(41, 120);
   endfunction

   // driver: offer queued bytes, predict each accepted one
   always @(posedge clock) begin : drive
      byte_slot_type slot;
      rsp_item_type  want;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (parse_byte(req_chan.data_byte, req_chan.start_req, want))
               parse_results.insert(parse_results.size(), want);
            n_accepted <= n_accepted + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (byte_stream.size() > 0 && byte_stream[0].gap > 0) begin
               byte_stream[0].gap = byte_stream[0].gap - 1;
               req_chan.valid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
               slot = byte_stream.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= slot.data_byte;
               req_chan.start_req <= slot.start_req;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) hold_left <= hold_left - 1;
         else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // monitor: check each result against the oldest prediction, drive ready
   always @(posedge clock) begin : watch
      rsp_item_type want;
      int           stall_left;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_results++;
            if (parse_results.size() == 0) begin
               report_mismatch("result with nothing expected, kind", 64'(rsp_chan.kind), '0);
            end else begin
               want = parse_results.pop_front();
               case (want.kind)
                  KIND_HEADER:  n_headers++;
                  KIND_PAYLOAD: n_payload++;
                  default:      n_faults++;
               endcase
               if (rsp_chan.kind !== want.kind)
                  report_mismatch("kind", 64'(rsp_chan.kind), 64'(want.kind));
               if (rsp_chan.frame_count !== want.frame_count)
                  report_mismatch("frame_count", rsp_chan.frame_count, want.frame_count);
               if (rsp_chan.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 64'(rsp_chan.payload_byte),
                                  64'(want.payload_byte));
               if (rsp_chan.last !== want.last)
                  report_mismatch("last", 64'(rsp_chan.last), 64'(want.last));
               if (rsp_chan.error_code !== want.error_code)
                  report_mismatch("error_code", 64'(rsp_chan.error_code),
                                  64'(want.error_code));
            end
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            // every fourth window of cycles runs without stalls
            if ((cyc / 1500) % 4 != 3 && $urandom_range(0, 99) < 25)
               stall_left = pick_gap(1'b0);
         end
      end
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cyc, parse_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int           r;
      int           n_pay;
      logic [63:0]  total;
      rsp_item_type want;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.start_req = 1'b0;
      rsp_chan.ready = 1'b0;

      // directed: stray byte while idle, each error, empty payload, start while busy
      put_byte(MAGIC_FIRST, 1'b0);
      build_msg(8'h00, MAGIC_SECOND, 8'(FIELD_BYTES), 64'd40, '0, 0);
      send_msg(1, 1);
      build_msg(MAGIC_FIRST, 8'h54, 8'(FIELD_BYTES), 64'd40, '0, 0);
      send_msg(2, 2);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'h00, 64'd40, '0, 0);
      send_msg(3, 3);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'hFF, 64'd40, '0, 0);
      send_msg(4, 3);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(HEADER_BYTES - 1), '0, 0);
      send_msg(13, 11);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), '0, '0, 0);
      send_msg(11, 11);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(BUFFER_BYTES + 1), '0, 0);
      send_msg(11, 11);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), '1, '0, 0);
      send_msg(11, 11);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(HEADER_BYTES), '1, 1);
      send_msg(HEADER_BYTES + 1, HEADER_BYTES);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(BUFFER_BYTES), '0, 3);
      send_msg(HEADER_BYTES + 3, HEADER_BYTES + 3);
      build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(HEADER_BYTES + 1), '1, 0);
      add_msg_byte(8'hFF);
      send_msg(HEADER_BYTES + 1, HEADER_BYTES + 1);

      // random: mostly well-formed messages, mixed with truncations, bad headers and noise
      while (n_counted < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) == 0) send_calm = !send_calm;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            n_pay = pick_payload();
            build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(HEADER_BYTES + n_pay),
                      rand_word(), n_pay);
            send_msg(msg_bytes.size(), msg_bytes.size());
         end else if (r < 68) begin
            n_pay = pick_payload();
            build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), 64'(HEADER_BYTES + n_pay),
                      rand_word(), n_pay);
            n_pay = $urandom_range(1, msg_bytes.size() - 1);
            send_msg(n_pay, n_pay);
         end else if (r < 73) begin
            build_msg(8'($urandom_range(0, 255)), MAGIC_SECOND, 8'(FIELD_BYTES), 64'd30,
                      '0, 11);
            if (msg_bytes[0] == MAGIC_FIRST) msg_bytes[0] = ~MAGIC_FIRST;
            send_msg(1 + $urandom_range(0, 3), 1);
         end else if (r < 77) begin
            build_msg(MAGIC_FIRST, 8'($urandom_range(0, 255)), 8'(FIELD_BYTES), 64'd30,
                      '0, 11);
            if (msg_bytes[1] == MAGIC_SECOND) msg_bytes[1] = ~MAGIC_SECOND;
            send_msg(2 + $urandom_range(0, 3), 2);
         end else if (r < 81) begin
            build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'($urandom_range(0, 255)), 64'd30, '0, 11);
            if (msg_bytes[2] == 8'(FIELD_BYTES)) msg_bytes[2] = 8'(FIELD_BYTES + 1);
            send_msg(3 + $urandom_range(0, 3), 3);
         end else if (r < 87) begin
            build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES),
                      64'($urandom_range(0, HEADER_BYTES - 1)), rand_word(), 2);
            send_msg(11 + $urandom_range(0, 3), 11);
         end else if (r < 93) begin
            total = rand_word();
            if (total <= 64'(BUFFER_BYTES)) total = total + 64'(BUFFER_BYTES + 1);
            if ($urandom_range(0, 3) == 0) total = 64'(BUFFER_BYTES + 1);
            build_msg(MAGIC_FIRST, MAGIC_SECOND, 8'(FIELD_BYTES), total, rand_word(), 2);
            send_msg(11 + $urandom_range(0, 3), 11);
         end else begin
            // stray bytes outside any message
            n_pay = $urandom_range(1, 5);
            for (int i = 0; i < n_pay; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (byte_stream.size() != 0 || req_chan.valid || parse_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      while (parse_results.size() != 0) begin
         want = parse_results.pop_front();
         report_mismatch("missing result of kind", '0, 64'(want.kind));
      end

      $display("run covered %0d bytes in %0d cycles: %0d headers, %0d payload bytes, %0d errors",
               n_accepted, cyc, n_headers, n_payload, n_faults);
      $display("receiver hold-off of %0d cycles applied: %0d, mismatches: %0d",
               HOLD_CYCLES, hold_done, n_errors);
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
